// ===== hdl/bbcc_pkg.sv =====
// shared constants, codes and result type of the byte block content classifier
`default_nettype none

package bbcc_pkg;

    // saturation bound of the byte and nonzero counts
    localparam int unsigned MAX_BYTES  = 65536;
    localparam int unsigned CNT_W      = $clog2(MAX_BYTES + 1);

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned DISTINCT_W = 9;
    localparam int unsigned COUNT_W    = 17;
    localparam int unsigned DELTA_W    = 24;
    localparam int unsigned LIMIT_W    = 9;
    localparam int unsigned VERDICT_W  = 2;

    // epoch tag kept per bitmap entry, zero is never a live epoch
    localparam int unsigned TAG_W      = 16;
    localparam int unsigned SEEN_DEPTH = 1 << BYTE_W;

    // apb register map
    localparam int unsigned ADDR_W     = 3;
    localparam int unsigned DATA_W     = 32;
    localparam logic        REG_FLAT   = 1'b0;
    localparam logic        REG_FRAME  = 1'b1;

    localparam logic [LIMIT_W-1:0] FLAT_LIMIT_RST  = LIMIT_W'(4);
    localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RST = LIMIT_W'(64);

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_FLAT   = 2'd0,
        VERDICT_FRAME  = 2'd1,
        VERDICT_SPARSE = 2'd2
    } verdict_t;

    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_DRAIN = 3'b010,
        ST_CLEAR = 3'b100
    } state_t;

    typedef struct packed {
        logic [DISTINCT_W-1:0] distinct_values;
        logic [COUNT_W-1:0]    nonzero_bytes;
        logic [COUNT_W-1:0]    byte_total;
        logic [DELTA_W-1:0]    neighbour_delta_sum;
        verdict_t              verdict;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/byte_block_content_classifier_core.sv =====
// top level of the byte block content classifier
`default_nettype none

// Byte block content classifier.
// Input channel: data_byte and last_byte, one byte per transfer (in_valid / in_stall).
// Output channel: one result per block, given for the transfer with last_byte set
// (out_valid / out_stall): distinct values, nonzero bytes, byte total, neighbour
// delta sum and a verdict (flat, frame, sparse).
// Configuration: apb port, flat_limit at address 0, frame_limit at address 4;
// write only while the block is idle.
// Throughput: one byte per cycle while in_stall is low. The presence bitmap lives
// in a 256 x 16 memory of epoch tags, read when a byte is taken and written back
// in the next cycle, so the read-modify-write loop of that memory sets the rate; a
// repeated byte in the next cycle is forwarded.
// A result passes the capture stage registers and then the result queue before it
// appears on the outputs.
// The output has a two-entry queue, so bytes keep flowing while a result waits;
// in_stall rises when both entries would be full and in the drain and clear states.
// Reset: limits return to 4 and 64, the counts clear, and a clearing pass writes
// each of the 256 bitmap tags to zero, in_stall high meanwhile. The same pass
// (after a drain state) runs after every 65535 blocks when the epoch wraps.
module byte_block_content_classifier_core (
    input  wire                           clk,
    input  wire                           rst_n,
    // input byte channel
    input  wire                           in_valid,
    output logic                          in_stall,
    input  wire  [bbcc_pkg::BYTE_W-1:0]   data_byte,
    input  wire                           last_byte,
    // result channel
    output logic                          out_valid,
    input  wire                           out_stall,
    output logic [bbcc_pkg::DISTINCT_W-1:0] distinct_values,
    output logic [bbcc_pkg::COUNT_W-1:0]  nonzero_bytes,
    output logic [bbcc_pkg::COUNT_W-1:0]  byte_total,
    output logic [bbcc_pkg::DELTA_W-1:0]  neighbour_delta_sum,
    output logic [bbcc_pkg::VERDICT_W-1:0] verdict,
    // configuration port
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [bbcc_pkg::ADDR_W-1:0]   paddr,
    input  wire  [bbcc_pkg::DATA_W-1:0]   pwdata,
    output logic [bbcc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import bbcc_pkg::*;

    // configuration registers
    logic [LIMIT_W-1:0]    flat_limit_reg;
    logic [LIMIT_W-1:0]    frame_limit_reg;

    // sequencer and clearing pass
    state_t                state_reg, state_next;
    logic [BYTE_W-1:0]     clr_ptr_reg, clr_ptr_next;
    logic [TAG_W-1:0]      epoch_reg, epoch_next;

    // bitmap memory
    logic [TAG_W-1:0]      seen_mem [SEEN_DEPTH];
    logic [TAG_W-1:0]      rd_tag_reg;
    logic                  mem_we;
    logic [BYTE_W-1:0]     mem_waddr;
    logic [TAG_W-1:0]      mem_wdata;

    // update stage
    logic                  s1_valid_reg;
    logic                  s1_last_reg;
    logic [BYTE_W-1:0]     s1_byte_reg;
    logic [TAG_W-1:0]      s1_tag_reg;
    logic                  fwd_hit_reg;

    // running block state
    logic [DISTINCT_W-1:0] distinct_reg;
    logic [CNT_W-1:0]      nonzero_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [DELTA_W-1:0]    delta_reg;
    logic [BYTE_W-1:0]     prev_byte_reg;
    logic                  first_reg;

    // result queue
    result_t               res_q_reg [2];
    logic                  q_head_reg, q_tail_reg;
    logic [1:0]            q_cnt_reg, q_cnt_next;

    logic                  in_accept;
    logic                  res_push;
    logic                  res_pop;
    logic                  wr_cfg;

    // ---------------------------------------------------------------
    // configuration port, register chosen by address bit 2
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign wr_cfg = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flat_limit_reg  <= FLAT_LIMIT_RST;
            frame_limit_reg <= FRAME_LIMIT_RST;
        end
        else if (wr_cfg)
        begin
            if (paddr[2] == REG_FLAT)
                flat_limit_reg <= pwdata[LIMIT_W-1:0];
            else
                frame_limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_FRAME)
            prdata = {{(DATA_W-LIMIT_W){1'b0}}, frame_limit_reg};
        else
            prdata = {{(DATA_W-LIMIT_W){1'b0}}, flat_limit_reg};
    end

    // ---------------------------------------------------------------
    // input handshake: stall while draining or clearing, or when the queue would fill
    // ---------------------------------------------------------------
    assign res_push   = s1_valid_reg && s1_last_reg;
    assign res_pop    = out_valid && !out_stall;
    assign q_cnt_next = q_cnt_reg + {1'b0, res_push} - {1'b0, res_pop};
    assign in_stall   = (state_reg != ST_RUN) || q_cnt_next[1];
    assign in_accept  = in_valid && !in_stall;

    // ---------------------------------------------------------------
    // sequencer: epoch advances per block, wrap triggers a clearing pass
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        clr_ptr_next = clr_ptr_reg;
        epoch_next   = epoch_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (in_accept && last_byte)
                begin
                    if (epoch_reg == {TAG_W{1'b1}})
                    begin
                        // let the final write-back land before clearing
                        epoch_next = TAG_W'(1);
                        state_next = ST_DRAIN;
                    end
                    else
                        epoch_next = epoch_reg + TAG_W'(1);
                end
            end
            ST_DRAIN:
            begin
                clr_ptr_next = '0;
                state_next   = ST_CLEAR;
            end
            ST_CLEAR:
            begin
                clr_ptr_next = clr_ptr_reg + BYTE_W'(1);
                if (clr_ptr_reg == {BYTE_W{1'b1}})
                    state_next = ST_RUN;
            end
            default:
            begin
                state_next   = ST_CLEAR;
                clr_ptr_next = '0;
                epoch_next   = TAG_W'(1);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_ptr_reg <= '0;
            epoch_reg   <= TAG_W'(1);
        end
        else
        begin
            state_reg   <= state_next;
            clr_ptr_reg <= clr_ptr_next;
            epoch_reg   <= epoch_next;
        end
    end

    // ---------------------------------------------------------------
    // bitmap memory: an entry is seen when its tag equals the block epoch
    // ---------------------------------------------------------------
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_ptr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = s1_valid_reg;
            mem_waddr = s1_byte_reg;
            mem_wdata = s1_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            seen_mem[mem_waddr] <= mem_wdata;
        if (in_accept)
            rd_tag_reg <= seen_mem[data_byte];
    end

    // capture stage, with forwarding of a write-back to the same entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= in_accept;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
            s1_tag_reg  <= epoch_reg;
            fwd_hit_reg <= s1_valid_reg && !s1_last_reg && (s1_byte_reg == data_byte);
        end
    end

    // ---------------------------------------------------------------
    // update stage: counts, delta sum and verdict
    // ---------------------------------------------------------------
    logic                  seen;
    logic [DISTINCT_W-1:0] distinct_new;
    logic [CNT_W-1:0]      nonzero_new;
    logic [CNT_W-1:0]      count_new;
    logic [BYTE_W-1:0]     diff;
    logic [DELTA_W:0]      delta_sum;
    logic [DELTA_W-1:0]    delta_new;
    verdict_t              verdict_new;
    result_t               res_new;

    always_comb
    begin
        seen         = fwd_hit_reg || (rd_tag_reg == s1_tag_reg);
        distinct_new = distinct_reg + {{(DISTINCT_W-1){1'b0}}, !seen};

        if (s1_byte_reg >= prev_byte_reg)
            diff = s1_byte_reg - prev_byte_reg;
        else
            diff = prev_byte_reg - s1_byte_reg;
        delta_sum = {1'b0, delta_reg} + {{(DELTA_W+1-BYTE_W){1'b0}}, diff};
        if (first_reg)
            delta_new = delta_reg;
        else if (delta_sum[DELTA_W])
            delta_new = {DELTA_W{1'b1}};
        else
            delta_new = delta_sum[DELTA_W-1:0];

        if ((s1_byte_reg != '0) && (nonzero_reg < CNT_W'(MAX_BYTES)))
            nonzero_new = nonzero_reg + CNT_W'(1);
        else
            nonzero_new = nonzero_reg;
        if (count_reg < CNT_W'(MAX_BYTES))
            count_new = count_reg + CNT_W'(1);
        else
            count_new = count_reg;

        if (distinct_new < flat_limit_reg)
            verdict_new = VERDICT_FLAT;
        else if ((distinct_new > frame_limit_reg)
                 && ({nonzero_new, 2'b00} > {2'b00, count_new}))
            verdict_new = VERDICT_FRAME;
        else
            verdict_new = VERDICT_SPARSE;

        res_new.distinct_values     = distinct_new;
        res_new.nonzero_bytes       = nonzero_new[COUNT_W-1:0];
        res_new.byte_total          = count_new[COUNT_W-1:0];
        res_new.neighbour_delta_sum = delta_new;
        res_new.verdict             = verdict_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            distinct_reg  <= '0;
            nonzero_reg   <= '0;
            count_reg     <= '0;
            delta_reg     <= '0;
            prev_byte_reg <= '0;
            first_reg     <= 1'b1;
        end
        else if (s1_valid_reg)
        begin
            if (s1_last_reg)
            begin
                // block done, start afresh
                distinct_reg  <= '0;
                nonzero_reg   <= '0;
                count_reg     <= '0;
                delta_reg     <= '0;
                prev_byte_reg <= '0;
                first_reg     <= 1'b1;
            end
            else
            begin
                distinct_reg  <= distinct_new;
                nonzero_reg   <= nonzero_new;
                count_reg     <= count_new;
                delta_reg     <= delta_new;
                prev_byte_reg <= s1_byte_reg;
                first_reg     <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // two-entry result queue
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (res_push)
            res_q_reg[q_tail_reg] <= res_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_head_reg <= 1'b0;
            q_tail_reg <= 1'b0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            if (res_push)
                q_tail_reg <= !q_tail_reg;
            if (res_pop)
                q_head_reg <= !q_head_reg;
            q_cnt_reg <= q_cnt_next;
        end
    end

    assign out_valid           = (q_cnt_reg != '0);
    assign distinct_values     = res_q_reg[q_head_reg].distinct_values;
    assign nonzero_bytes       = res_q_reg[q_head_reg].nonzero_bytes;
    assign byte_total          = res_q_reg[q_head_reg].byte_total;
    assign neighbour_delta_sum = res_q_reg[q_head_reg].neighbour_delta_sum;
    assign verdict             = res_q_reg[q_head_reg].verdict;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // the queue never holds more than two results
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg != 2'd3)
        else $error("result queue overrun");

    // a result is never pushed into a full queue that is not draining
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && q_cnt_reg == 2'd2) |-> res_pop)
        else $error("result pushed into full queue");

    // no bitmap update is in flight while the clearing pass writes
    a_clear_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s1_valid_reg)
        else $error("write-back collides with clearing pass");

    // zero is the cleared tag and must never be a live epoch
    a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_reg != '0)
        else $error("epoch reached cleared tag value");

endmodule

`default_nettype wire
